### src/mlpq_pkg.sv
// Shared constants, types and helpers of the multilevel priority queue.
`default_nettype none
package mlpq_pkg;

   localparam int LEVELS    = 8;
   localparam int DEPTH     = 16;
   localparam int INFO_BITS = 16;

   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(LEVELS * DEPTH);

   localparam logic [2:0] MAX_PRIORITY_RESET = 3'd5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef logic [LVL_W-1:0]     level_type;
   typedef logic [PTR_W-1:0]     ptr_type;
   typedef logic [CNT_W-1:0]     count_type;
   typedef logic [INFO_BITS-1:0] tag_type;
   typedef logic [ADDR_W-1:0]    addr_type;

   typedef logic [LEVELS-1:0][CNT_W-1:0] count_vec_type;
   typedef logic [LEVELS-1:0][PTR_W-1:0] ptr_vec_type;
   typedef logic [LEVELS-1:0][INFO_BITS-1:0] tag_vec_type;

   // Outcome of one request, carried from the level update to head selection.
   typedef struct packed {
      status_type status;
      logic       set_head;    // front tag of level changes
      logic       from_store;  // new front tag comes from the tag store read
      level_type  level;
      tag_type    tag;
   } op_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      tag_type  wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  level;
      logic [15:0] info;
   } head_type;

   function automatic ptr_type ring_next(ptr_type p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic addr_type slot_addr(level_type l, ptr_type p);
      return ADDR_W'(l) * ADDR_W'(DEPTH) + ADDR_W'(p);
   endfunction

endpackage
`default_nettype wire

### src/multilevel_priority_queue.sv
// Top level of the multilevel priority queue: handshakes, config register, result register.
// Stages: level update and tag store read register on accept; head selection works on those
//   registers, and its result enters the result register when the selected stage advances.
// Throughput: one request per cycle while rsp_tready is high; a waiting result holds the
//   selected stage, and req_tready then follows rsp_tready in the same cycle.
// Reset (synchronous): clear counts and ring pointers, set max_priority to 5, keep tag store.
`default_nettype none
module multilevel_priority_queue (
   input  wire         clock,
   input  wire         reset,
   // config register
   input  wire         csr_wr_en,
   input  wire  [2:0]  csr_wr_data,   // max_priority
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [0:0]  req_tuser,     // [0] kind
   input  wire  [23:0] req_tdata,     // [2:0] priority_req, [18:3] info, [23:19] zero
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata      // [1:0] status, [2] head_valid, [5:3] head_priority,
                                      // [21:6] head_info, [23:22] zero
);

   logic [2:0] max_priority_ff;

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;

   logic accept;
   logic advance;

   mlpq_pkg::op_type        op;
   mlpq_pkg::count_vec_type counts;
   mlpq_pkg::mem_req_type   mem_req;
   mlpq_pkg::tag_type       rd_data;
   mlpq_pkg::head_type      head;

   // Hold max_priority until the next write.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_priority_ff <= mlpq_pkg::MAX_PRIORITY_RESET;
      end else if (csr_wr_en) begin
         max_priority_ff <= csr_wr_data;
      end
   end

   // Advance the selected stage into the result register whenever that register is free
   // or being emptied; take a new request whenever the selected stage moves on.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Update counts and pointers, write or read the tag store in the accept cycle.
   mlpq_level_ctrl u_level_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_tuser[0]),
      .priority_req (req_tdata[2:0]),
      .info         (req_tdata[18:3]),
      .max_priority (max_priority_ff),
      .op           (op),
      .counts       (counts),
      .mem_req      (mem_req)
   );

   mlpq_tag_store u_tag_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Pick the highest non-empty level and its front tag after the request.
   mlpq_head_select u_head_select (
      .clock    (clock),
      .op_valid (s1_valid_ff),
      .advance  (advance),
      .op       (op),
      .counts   (counts),
      .rd_data  (rd_data),
      .head     (head)
   );

   // Hold the result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, head.info, head.level, head.valid, op.status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### src/mlpq_tag_store.sv
// Tag store: one memory of LEVELS*DEPTH tags with a registered read port.
`default_nettype none
module mlpq_tag_store (
   input  wire                   clock,
   input  mlpq_pkg::mem_req_type mem_req,
   output mlpq_pkg::tag_type     rd_data
);

   mlpq_pkg::tag_type mem [mlpq_pkg::LEVELS * mlpq_pkg::DEPTH];
   mlpq_pkg::tag_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/mlpq_level_ctrl.sv
// Level control: per-level counts and ring pointers, request status, store access.
`default_nettype none
module mlpq_level_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  wire                     kind,
   input  wire  [2:0]              priority_req,
   input  wire  [15:0]             info,
   input  wire  [2:0]              max_priority,
   output mlpq_pkg::op_type        op,
   output mlpq_pkg::count_vec_type counts,
   output mlpq_pkg::mem_req_type   mem_req
);

   mlpq_pkg::count_vec_type count_ff, count_in;
   mlpq_pkg::ptr_vec_type   head_ptr_ff, head_ptr_in;
   mlpq_pkg::ptr_vec_type   tail_ptr_ff, tail_ptr_in;
   mlpq_pkg::op_type        op_ff, op_in;

   logic                  lvl_ok;
   mlpq_pkg::level_type   idx;
   mlpq_pkg::count_type   cnt;
   mlpq_pkg::ptr_type     hp;
   mlpq_pkg::ptr_type     tp;
   mlpq_pkg::tag_type     tag;
   logic [63:0]           info_wide;

   always_comb begin
      lvl_ok    = (32'(priority_req) < mlpq_pkg::LEVELS);
      idx       = mlpq_pkg::LVL_W'(priority_req);
      cnt       = count_ff[idx];
      hp        = head_ptr_ff[idx];
      tp        = tail_ptr_ff[idx];
      info_wide = 64'(info);
      tag       = info_wide[mlpq_pkg::INFO_BITS-1:0];

      count_in    = count_ff;
      head_ptr_in = head_ptr_ff;
      tail_ptr_in = tail_ptr_ff;

      op_in.status     = mlpq_pkg::STATUS_OK;
      op_in.set_head   = 1'b0;
      op_in.from_store = 1'b0;
      op_in.level      = idx;
      op_in.tag        = tag;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = mlpq_pkg::slot_addr(idx, tp);
      mem_req.wr_data = tag;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = mlpq_pkg::slot_addr(idx, mlpq_pkg::ring_next(hp));

      if (kind == mlpq_pkg::KIND_INSERT) begin
         priority if (priority_req > max_priority || !lvl_ok) begin
            op_in.status = mlpq_pkg::STATUS_DROPPED;
         end else if (cnt == mlpq_pkg::CNT_W'(mlpq_pkg::DEPTH)) begin
            op_in.status = mlpq_pkg::STATUS_FULL;
         end else begin
            mem_req.wr_en    = accept;
            tail_ptr_in[idx] = mlpq_pkg::ring_next(tp);
            count_in[idx]    = cnt + 1'b1;
            op_in.set_head   = (cnt == '0);
         end
      end else begin
         priority if (!lvl_ok || cnt == '0) begin
            op_in.status = mlpq_pkg::STATUS_EMPTY;
         end else begin
            mem_req.rd_en    = accept;
            head_ptr_in[idx] = mlpq_pkg::ring_next(hp);
            count_in[idx]    = cnt - 1'b1;
            op_in.set_head   = (cnt != mlpq_pkg::CNT_W'(1));
            op_in.from_store = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         head_ptr_ff <= '0;
         tail_ptr_ff <= '0;
      end else if (accept) begin
         count_ff    <= count_in;
         head_ptr_ff <= head_ptr_in;
         tail_ptr_ff <= tail_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_in;
      end
   end

   assign op     = op_ff;
   assign counts = count_ff;

endmodule
`default_nettype wire

### src/mlpq_head_select.sv
// Head selection: per-level front tags and the priority encoder over levels.
`default_nettype none
module mlpq_head_select (
   input  wire                     clock,
   input  wire                     op_valid,
   input  wire                     advance,
   input  mlpq_pkg::op_type        op,
   input  mlpq_pkg::count_vec_type counts,
   input  mlpq_pkg::tag_type       rd_data,
   output mlpq_pkg::head_type      head
);

   mlpq_pkg::tag_vec_type front_ff, front_in;
   logic                  found;
   mlpq_pkg::level_type   sel;
   logic [63:0]           tag_wide;

   always_comb begin
      front_in = front_ff;
      if (op_valid && op.set_head) begin
         front_in[op.level] = op.from_store ? rd_data : op.tag;
      end

      found = 1'b0;
      sel   = '0;
      for (int l = 0; l < mlpq_pkg::LEVELS; l++) begin
         if (counts[l] != '0) begin
            found = 1'b1;
            sel   = mlpq_pkg::LVL_W'(l);
         end
      end

      tag_wide   = 64'(front_in[sel]);
      head.valid = found;
      head.level = found ? 3'(sel) : 3'd0;
      head.info  = found ? tag_wide[15:0] : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_ff <= front_in;
      end
   end

endmodule
`default_nettype wire
